>>> rtl/core/ptah_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptah_pkg
// Shared types, widths and the CORDIC arctangent table for the polygon
// turn-angle histogram core.
// ============================================================================
package ptah_pkg;

    localparam int MAX_BINS     = 64;
    localparam int BIN_W        = 6;
    localparam int BINC_W       = 7;
    localparam int COORD_W      = 24;
    localparam int DIFF_W       = 25;
    localparam int CW           = 28;   // CORDIC x/y datapath
    localparam int ANGLE_W      = 16;
    localparam int Z_W          = 32;
    localparam int ITER         = 32;
    localparam int ITER_W       = 6;
    localparam int VCNT_W       = 17;
    localparam int MAX_VERTICES = 65536;
    localparam int SHARE_W      = 17;
    localparam int FULL_SHARE   = 65536;
    localparam int TOTAL_W      = 32;
    localparam int PROD_W       = 49;
    localparam int DIV_W        = 50;   // dividend / quotient bits
    localparam int DVSR_W       = 33;
    localparam int DCNT_W       = 6;
    localparam int BIN_RESET    = 36;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TURN_EDGE,
        TURN_CLOSE_A,
        TURN_CLOSE_B
    } turn_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE_CHECK,
        ST_CORDIC,
        ST_DIR,
        ST_TURN_RD,
        ST_TURN_WR,
        ST_FIN_RD,
        ST_FIN_LD,
        ST_DIV,
        ST_MUL,
        ST_DIV2_LD,
        ST_FIN_WR,
        ST_READ_RD,
        ST_READ_OUT
    } state_t;

    // atan(2^-i) as a fraction of a full turn (2^32)
    function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] i);
        logic [Z_W-1:0] t;
        unique case (i)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            5'd31: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/core/polygon_turn_angle_histogram_core.sv
`timescale 1ns / 1ps
// ============================================================================
// polygon_turn_angle_histogram_core
// Turn-angle histogram of streamed polygons with running bin averages.
// ============================================================================
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  input   | s_valid s_ready s_kind s_coord_x/y      | in
//          | s_closes_polygon                        |
//  result  | m_valid m_ready m_bin_index             | out
//          | m_average_fraction m_polygons_seen      |
//          | m_last_bin                              |
//  config  | cfg_wr_en cfg_wr_data                   | in
//
// One item at a time (s_ready only in idle): a polygon's first vertex goes to the
// close check; any other vertex runs a CORDIC pass and the direction step, a bin
// read and write per counted turn, then the close check; a closing vertex adds a
// CORDIC pass with direction and two turns, then per bin 2 restoring divisions
// plus memory read/multiply/write. A read item reads each bin in turn and waits
// out output stalls. Clear completes in idle.
// Reset is synchronous; valid bits clear the bin memories at once.
// ============================================================================
module polygon_turn_angle_histogram_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ptah_pkg::BINC_W-1:0]            cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_kind,
    input  logic signed [ptah_pkg::COORD_W-1:0]    s_coord_x,
    input  logic signed [ptah_pkg::COORD_W-1:0]    s_coord_y,
    input  logic                                   s_closes_polygon,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ptah_pkg::BIN_W-1:0]             m_bin_index,
    output logic [ptah_pkg::SHARE_W-1:0]           m_average_fraction,
    output logic [ptah_pkg::TOTAL_W-1:0]           m_polygons_seen,
    output logic                                   m_last_bin
);

    ptah_pkg::state_t state_reg, state_next;

    logic [ptah_pkg::BINC_W-1:0]          bin_count_reg;
    logic [ptah_pkg::BINC_W-1:0]          nb;
    logic signed [ptah_pkg::COORD_W-1:0]  first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [ptah_pkg::ANGLE_W-1:0]         first_dir_reg, prev_dir_reg, dc_reg;
    logic [ptah_pkg::VCNT_W-1:0]          vc_reg;
    logic [ptah_pkg::TOTAL_W-1:0]         total_reg;
    logic                                 closes_reg, cord_close_reg;

    // CORDIC
    logic signed [ptah_pkg::CW-1:0]       cx_reg, cy_reg, cx_step, cy_step, shx, shy;
    logic [ptah_pkg::Z_W-1:0]             cz_reg, cz_step, z_round;
    logic [ptah_pkg::ITER_W-1:0]          ccnt_reg;
    logic signed [ptah_pkg::DIFF_W-1:0]   cdx, cdy;
    logic signed [ptah_pkg::CW-1:0]       cx0, cy0;
    logic [ptah_pkg::ANGLE_W-1:0]         dir_w;

    // turn binning
    ptah_pkg::turn_sel_t                  turn_sel_reg;
    logic [ptah_pkg::ANGLE_W-1:0]         turn_in_reg, turn_out_reg, turn_w;
    logic [22:0]                          bin_prod;
    logic [ptah_pkg::BIN_W-1:0]           bin_w, bin_reg;

    // bin memories with valid bits
    logic [ptah_pkg::VCNT_W-1:0]          hits_mem [ptah_pkg::MAX_BINS];
    logic [ptah_pkg::SHARE_W-1:0]         avg_mem  [ptah_pkg::MAX_BINS];
    logic [ptah_pkg::VCNT_W-1:0]          hits_rdata_reg, hits_v, hits_wdata;
    logic [ptah_pkg::SHARE_W-1:0]         avg_rdata_reg, avg_v;
    logic [ptah_pkg::MAX_BINS-1:0]        hits_vld_reg, avg_vld_reg;
    logic [ptah_pkg::BIN_W-1:0]           hits_addr_reg, avg_addr_reg, hits_raddr, avg_raddr;
    logic                                 hits_re, hits_we, avg_re, avg_we;

    // finish / divider
    logic [ptah_pkg::BIN_W-1:0]           fin_b_reg, rb_reg;
    logic [ptah_pkg::SHARE_W-1:0]         avg_old_reg, frac_reg;
    logic [ptah_pkg::PROD_W-1:0]          prod_reg;
    logic [ptah_pkg::DIV_W-1:0]           dq_reg;
    logic [ptah_pkg::DVSR_W-1:0]          drem_reg, dvsr_reg;
    logic [ptah_pkg::DVSR_W:0]            dtrial, ddiff;
    logic [ptah_pkg::DCNT_W-1:0]          dcnt_reg;
    logic                                 div_second_reg;
    logic                                 last_fin, last_rd, s_acc;

    function automatic logic signed [ptah_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic signed [ptah_pkg::COORD_W-1:0] v);
        return {v[ptah_pkg::COORD_W-1], v};
    endfunction

    function automatic logic signed [ptah_pkg::CW-1:0] CW_EXT(
        input logic signed [ptah_pkg::DIFF_W-1:0] v);
        return {{(ptah_pkg::CW - ptah_pkg::DIFF_W){v[ptah_pkg::DIFF_W-1]}}, v};
    endfunction

    // effective bin count, clamped to 1..MAX_BINS
    always_comb begin
        if (bin_count_reg == '0) begin
            nb = 7'd1;
        end else if (bin_count_reg > 7'(ptah_pkg::MAX_BINS)) begin
            nb = 7'(ptah_pkg::MAX_BINS);
        end else begin
            nb = bin_count_reg;
        end
    end

    assign last_fin = ({1'b0, fin_b_reg} == nb - 7'd1);
    assign last_rd  = ({1'b0, rb_reg} == nb - 7'd1);
    assign s_acc    = s_valid && s_ready;

    // edge vector for a new CORDIC pass
    always_comb begin
        if (state_reg == ptah_pkg::ST_IDLE) begin
            cdx = DIFF_EXT(s_coord_x) - DIFF_EXT(prev_x_reg);
            cdy = DIFF_EXT(s_coord_y) - DIFF_EXT(prev_y_reg);
        end else begin
            cdx = DIFF_EXT(first_x_reg) - DIFF_EXT(prev_x_reg);
            cdy = DIFF_EXT(first_y_reg) - DIFF_EXT(prev_y_reg);
        end
        if (cdx[ptah_pkg::DIFF_W-1]) begin
            cx0 = -CW_EXT(cdx);
            cy0 = -CW_EXT(cdy);
        end else begin
            cx0 = CW_EXT(cdx);
            cy0 = CW_EXT(cdy);
        end
    end

    // one CORDIC rotation
    always_comb begin
        shx = cx_reg >>> ccnt_reg[4:0];
        shy = cy_reg >>> ccnt_reg[4:0];
        if (!cy_reg[ptah_pkg::CW-1]) begin
            cx_step = cx_reg + shy;
            cy_step = cy_reg - shx;
            cz_step = cz_reg + ptah_pkg::atan_turn(ccnt_reg[4:0]);
        end else begin
            cx_step = cx_reg - shy;
            cy_step = cy_reg + shx;
            cz_step = cz_reg - ptah_pkg::atan_turn(ccnt_reg[4:0]);
        end
        z_round = cz_reg + 32'h0000_8000;
        dir_w   = z_round[31:16];
    end

    // turn angle to bin
    always_comb begin
        turn_w   = 16'h8000 + turn_in_reg - turn_out_reg;
        bin_prod = {7'd0, turn_w} * {16'd0, nb};
        bin_w    = bin_prod[21:16];
    end

    // restoring division step
    always_comb begin
        dtrial = {drem_reg, dq_reg[ptah_pkg::DIV_W-1]};
        ddiff  = dtrial - {1'b0, dvsr_reg};
    end

    assign hits_v     = hits_vld_reg[hits_addr_reg] ? hits_rdata_reg : '0;
    assign avg_v      = avg_vld_reg[avg_addr_reg] ? avg_rdata_reg : '0;
    assign hits_wdata = (hits_v < 17'(ptah_pkg::MAX_VERTICES)) ? hits_v + 17'd1 : hits_v;
    assign hits_raddr = (state_reg == ptah_pkg::ST_TURN_RD) ? bin_w : fin_b_reg;
    assign avg_raddr  = (state_reg == ptah_pkg::ST_READ_RD) ? rb_reg : fin_b_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptah_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_kind == ptah_pkg::KIND_VERTEX) begin
                        state_next = (vc_reg == '0) ? ptah_pkg::ST_CLOSE_CHECK
                                                    : ptah_pkg::ST_CORDIC;
                    end else if (s_kind == ptah_pkg::KIND_READ) begin
                        state_next = ptah_pkg::ST_READ_RD;
                    end
                end
            end
            ptah_pkg::ST_CLOSE_CHECK: begin
                if (closes_reg && vc_reg >= 17'd3) begin
                    state_next = ptah_pkg::ST_CORDIC;
                end else begin
                    state_next = ptah_pkg::ST_IDLE;
                end
            end
            ptah_pkg::ST_CORDIC: begin
                if (ccnt_reg == 6'(ptah_pkg::ITER)) state_next = ptah_pkg::ST_DIR;
            end
            ptah_pkg::ST_DIR: begin
                if (cord_close_reg || vc_reg >= 17'd2) begin
                    state_next = ptah_pkg::ST_TURN_RD;
                end else begin
                    state_next = ptah_pkg::ST_CLOSE_CHECK;
                end
            end
            ptah_pkg::ST_TURN_RD: state_next = ptah_pkg::ST_TURN_WR;
            ptah_pkg::ST_TURN_WR: begin
                unique case (turn_sel_reg)
                    ptah_pkg::TURN_EDGE:    state_next = ptah_pkg::ST_CLOSE_CHECK;
                    ptah_pkg::TURN_CLOSE_A: state_next = ptah_pkg::ST_TURN_RD;
                    default:                state_next = ptah_pkg::ST_FIN_RD;
                endcase
            end
            ptah_pkg::ST_FIN_RD:  state_next = ptah_pkg::ST_FIN_LD;
            ptah_pkg::ST_FIN_LD:  state_next = ptah_pkg::ST_DIV;
            ptah_pkg::ST_DIV: begin
                if (dcnt_reg == 6'(ptah_pkg::DIV_W - 1)) begin
                    state_next = div_second_reg ? ptah_pkg::ST_FIN_WR : ptah_pkg::ST_MUL;
                end
            end
            ptah_pkg::ST_MUL:     state_next = ptah_pkg::ST_DIV2_LD;
            ptah_pkg::ST_DIV2_LD: state_next = ptah_pkg::ST_DIV;
            ptah_pkg::ST_FIN_WR: begin
                state_next = last_fin ? ptah_pkg::ST_IDLE : ptah_pkg::ST_FIN_RD;
            end
            ptah_pkg::ST_READ_RD: state_next = ptah_pkg::ST_READ_OUT;
            ptah_pkg::ST_READ_OUT: begin
                if (m_ready) state_next = last_rd ? ptah_pkg::ST_IDLE : ptah_pkg::ST_READ_RD;
            end
            default: state_next = ptah_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory strobes
    always_comb begin
        s_ready = (state_reg == ptah_pkg::ST_IDLE);
        m_valid = (state_reg == ptah_pkg::ST_READ_OUT);
        hits_re = (state_reg == ptah_pkg::ST_TURN_RD) || (state_reg == ptah_pkg::ST_FIN_RD);
        hits_we = (state_reg == ptah_pkg::ST_TURN_WR);
        avg_re  = (state_reg == ptah_pkg::ST_FIN_RD) || (state_reg == ptah_pkg::ST_READ_RD);
        avg_we  = (state_reg == ptah_pkg::ST_FIN_WR);
    end

    assign m_bin_index        = rb_reg;
    assign m_average_fraction = avg_v;
    assign m_polygons_seen    = total_reg;
    assign m_last_bin         = last_rd;

    // bin memories
    always_ff @(posedge aclk) begin
        if (hits_we) hits_mem[bin_reg] <= hits_wdata;
        if (hits_re) hits_rdata_reg <= hits_mem[hits_raddr];
        if (avg_we)  avg_mem[fin_b_reg] <= dq_reg[ptah_pkg::SHARE_W-1:0];
        if (avg_re)  avg_rdata_reg <= avg_mem[avg_raddr];
    end

    // control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptah_pkg::ST_IDLE;
            bin_count_reg  <= 7'(ptah_pkg::BIN_RESET);
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            first_dir_reg  <= '0;
            prev_dir_reg   <= '0;
            vc_reg         <= '0;
            total_reg      <= '0;
            hits_vld_reg   <= '0;
            avg_vld_reg    <= '0;
            closes_reg     <= 1'b0;
            cord_close_reg <= 1'b0;
            turn_sel_reg   <= ptah_pkg::TURN_EDGE;
            div_second_reg <= 1'b0;
            ccnt_reg       <= '0;
            dcnt_reg       <= '0;
            fin_b_reg      <= '0;
            rb_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) bin_count_reg <= cfg_wr_data;
            if (hits_re) hits_addr_reg <= hits_raddr;
            if (avg_re)  avg_addr_reg  <= avg_raddr;

            unique case (state_reg)
                ptah_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        closes_reg     <= s_closes_polygon;
                        cord_close_reg <= 1'b0;
                        if (s_kind == ptah_pkg::KIND_VERTEX) begin
                            if (vc_reg == '0) begin
                                first_x_reg <= s_coord_x;
                                first_y_reg <= s_coord_y;
                                prev_x_reg  <= s_coord_x;
                                prev_y_reg  <= s_coord_y;
                                vc_reg      <= 17'd1;
                            end else begin
                                prev_x_reg <= s_coord_x;
                                prev_y_reg <= s_coord_y;
                                cx_reg     <= cx0;
                                cy_reg     <= cy0;
                                cz_reg     <= cdx[ptah_pkg::DIFF_W-1] ? 32'h8000_0000 : '0;
                                // zero-length edge: skip straight to direction 0
                                ccnt_reg   <= (cdx == '0 && cdy == '0) ?
                                              6'(ptah_pkg::ITER) : '0;
                            end
                        end else if (s_kind == ptah_pkg::KIND_CLEAR) begin
                            avg_vld_reg  <= '0;
                            total_reg    <= '0;
                            vc_reg       <= '0;
                            hits_vld_reg <= '0;
                        end else if (s_kind == ptah_pkg::KIND_READ) begin
                            rb_reg <= '0;
                        end
                    end
                end
                ptah_pkg::ST_CLOSE_CHECK: begin
                    if (closes_reg && vc_reg >= 17'd3) begin
                        cord_close_reg <= 1'b1;
                        cx_reg   <= cx0;
                        cy_reg   <= cy0;
                        cz_reg   <= cdx[ptah_pkg::DIFF_W-1] ? 32'h8000_0000 : '0;
                        ccnt_reg <= (cdx == '0 && cdy == '0) ? 6'(ptah_pkg::ITER) : '0;
                    end else if (closes_reg) begin
                        vc_reg       <= '0;
                        hits_vld_reg <= '0;
                    end
                end
                ptah_pkg::ST_CORDIC: begin
                    if (ccnt_reg != 6'(ptah_pkg::ITER)) begin
                        cx_reg   <= cx_step;
                        cy_reg   <= cy_step;
                        cz_reg   <= cz_step;
                        ccnt_reg <= ccnt_reg + 6'd1;
                    end
                end
                ptah_pkg::ST_DIR: begin
                    turn_in_reg  <= prev_dir_reg;
                    turn_out_reg <= dir_w;
                    if (cord_close_reg) begin
                        dc_reg       <= dir_w;
                        turn_sel_reg <= ptah_pkg::TURN_CLOSE_A;
                    end else begin
                        turn_sel_reg <= ptah_pkg::TURN_EDGE;
                        prev_dir_reg <= dir_w;
                        if (vc_reg == 17'd1) first_dir_reg <= dir_w;
                        if (vc_reg < 17'(ptah_pkg::MAX_VERTICES)) vc_reg <= vc_reg + 17'd1;
                    end
                end
                ptah_pkg::ST_TURN_RD: begin
                    bin_reg <= bin_w;
                end
                ptah_pkg::ST_TURN_WR: begin
                    hits_vld_reg[bin_reg] <= 1'b1;
                    if (turn_sel_reg == ptah_pkg::TURN_CLOSE_A) begin
                        turn_in_reg  <= dc_reg;
                        turn_out_reg <= first_dir_reg;
                        turn_sel_reg <= ptah_pkg::TURN_CLOSE_B;
                    end else if (turn_sel_reg == ptah_pkg::TURN_CLOSE_B) begin
                        fin_b_reg <= '0;
                    end
                end
                ptah_pkg::ST_FIN_RD: begin
                end
                ptah_pkg::ST_FIN_LD: begin
                    // hits * 65536 / vertices
                    avg_old_reg    <= avg_v;
                    dq_reg         <= {17'd0, hits_v, 16'd0};
                    dvsr_reg       <= {16'd0, vc_reg};
                    drem_reg       <= '0;
                    dcnt_reg       <= '0;
                    div_second_reg <= 1'b0;
                end
                ptah_pkg::ST_DIV: begin
                    if (!ddiff[ptah_pkg::DVSR_W]) begin
                        drem_reg <= ddiff[ptah_pkg::DVSR_W-1:0];
                        dq_reg   <= {dq_reg[ptah_pkg::DIV_W-2:0], 1'b1};
                    end else begin
                        drem_reg <= dtrial[ptah_pkg::DVSR_W-1:0];
                        dq_reg   <= {dq_reg[ptah_pkg::DIV_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
                ptah_pkg::ST_MUL: begin
                    frac_reg <= (dq_reg > 50'(ptah_pkg::FULL_SHARE)) ?
                                17'(ptah_pkg::FULL_SHARE) : dq_reg[ptah_pkg::SHARE_W-1:0];
                    prod_reg <= {32'd0, avg_old_reg} * {17'd0, total_reg};
                end
                ptah_pkg::ST_DIV2_LD: begin
                    // (old * n + frac) / (n + 1)
                    dq_reg         <= {1'b0, prod_reg + {32'd0, frac_reg}};
                    dvsr_reg       <= {1'b0, total_reg} + 33'd1;
                    drem_reg       <= '0;
                    dcnt_reg       <= '0;
                    div_second_reg <= 1'b1;
                end
                ptah_pkg::ST_FIN_WR: begin
                    avg_vld_reg[fin_b_reg] <= 1'b1;
                    if (last_fin) begin
                        if (total_reg != '1) total_reg <= total_reg + 32'd1;
                        vc_reg       <= '0;
                        hits_vld_reg <= '0;
                    end else begin
                        fin_b_reg <= fin_b_reg + 6'd1;
                    end
                end
                ptah_pkg::ST_READ_RD: begin
                end
                ptah_pkg::ST_READ_OUT: begin
                    if (m_ready && !last_rd) rb_reg <= rb_reg + 6'd1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the polygon turn-angle histogram core. Streams
// directed and random polygons, clears, read-outs and ignored items through
// the valid/ready input channel. A built-in predictor (CORDIC edge direction,
// turn binning, running bin averages) builds the expected read-out items,
// which are checked field by field against the result channel.
// ============================================================================
module testbench;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 8000;   // covers a closing vertex at 64 bins

    typedef struct {
        ptah_pkg::kind_t    kind;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               closes;
    } stim_item_t;

    typedef struct {
        logic [5:0]  bin;
        logic [16:0] share;
        logic [31:0] total;
        logic        last;
    } bin_report_t;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [6:0]         cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = '0;
    logic signed [23:0] s_coord_x = '0;
    logic signed [23:0] s_coord_y = '0;
    logic               s_closes_polygon = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_bin_index;
    logic [16:0]        m_average_fraction;
    logic [31:0]        m_polygons_seen;
    logic               m_last_bin;

    polygon_turn_angle_histogram_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_coord_x          (s_coord_x),
        .s_coord_y          (s_coord_y),
        .s_closes_polygon   (s_closes_polygon),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bin_index        (m_bin_index),
        .m_average_fraction (m_average_fraction),
        .m_polygons_seen    (m_polygons_seen),
        .m_last_bin         (m_last_bin)
    );

    always #10 aclk = ~aclk;

    stim_item_t  pending_items[$];
    bin_report_t expected_bins[$];
    int          errors = 0;
    int          sender_idle_pct = 15;
    int          receiver_idle_pct = 50;
    int          quiet_cycles = 0;

    // predictor state
    int unsigned  bin_setting = ptah_pkg::BIN_RESET;
    longint       first_x, first_y, prev_x, prev_y;
    int unsigned  first_dir, prev_dir, vtx_count;
    int unsigned  hits [64];
    int unsigned  avg_share [64];
    int unsigned  poly_total;

    function automatic int unsigned active_bins();
        if (bin_setting == 0) return 1;
        if (bin_setting > 64) return 64;
        return bin_setting;
    endfunction

    // iterative CORDIC vectoring, 16-bit binary angle
    function automatic int unsigned edge_direction(longint dx, longint dy);
        longint      cx, cy, nx, ny;
        logic [31:0] z;
        if (dx == 0 && dy == 0) return 0;
        cx = dx;
        cy = dy;
        z = 32'h0;
        if (dx < 0) begin
            cx = -dx;
            cy = -dy;
            z = 32'h80000000;
        end
        for (int i = 0; i < 32; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                z = z + ATAN_STEP[i];
            end else begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                z = z - ATAN_STEP[i];
            end
            cx = nx;
            cy = ny;
        end
        z = z + 32'h8000;
        return {16'd0, z[31:16]};
    endfunction

    function automatic void tally_turn(int unsigned in_dir, int unsigned out_dir);
        int unsigned turn, b;
        turn = (32768 + in_dir - out_dir) & 16'hFFFF;
        b = (turn * active_bins()) >> 16;
        if (b > 63) b = 63;
        if (hits[b] < ptah_pkg::MAX_VERTICES) hits[b]++;
    endfunction

    function automatic void drop_polygon();
        vtx_count = 0;
        foreach (hits[i]) hits[i] = 0;
    endfunction

    function automatic void fold_polygon();
        longint unsigned frac, n;
        n = poly_total;
        for (int b = 0; b < active_bins(); b++) begin
            frac = (longint'(hits[b]) * 65536) / vtx_count;
            if (frac > 65536) frac = 65536;
            avg_share[b] = 32'((longint'(avg_share[b]) * n + frac) / (n + 1));
        end
        if (poly_total != 32'hFFFFFFFF) poly_total++;
    endfunction

    function automatic void reset_histogram();
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        first_dir = 0; prev_dir = 0; poly_total = 0;
        foreach (avg_share[i]) avg_share[i] = 0;
        drop_polygon();
    endfunction

    // advance the predictor by one accepted item
    function automatic void predict_histogram(stim_item_t it);
        longint      x, y;
        int unsigned d, dc;
        bin_report_t r;
        case (it.kind)
            ptah_pkg::KIND_VERTEX: begin
                x = longint'(it.x);
                y = longint'(it.y);
                if (vtx_count == 0) begin
                    first_x = x;
                    first_y = y;
                end else begin
                    d = edge_direction(x - prev_x, y - prev_y);
                    if (vtx_count == 1) first_dir = d;
                    else tally_turn(prev_dir, d);
                    prev_dir = d;
                end
                prev_x = x;
                prev_y = y;
                if (vtx_count < ptah_pkg::MAX_VERTICES) vtx_count++;
                if (it.closes) begin
                    if (vtx_count >= 3) begin
                        dc = edge_direction(first_x - x, first_y - y);
                        tally_turn(prev_dir, dc);
                        tally_turn(dc, first_dir);
                        fold_polygon();
                    end
                    drop_polygon();
                end
            end
            ptah_pkg::KIND_CLEAR: begin
                foreach (avg_share[i]) avg_share[i] = 0;
                poly_total = 0;
                drop_polygon();
            end
            ptah_pkg::KIND_READ: begin
                for (int b = 0; b < active_bins(); b++) begin
                    r.bin = 6'(b);
                    r.share = 17'(avg_share[b]);
                    r.total = poly_total;
                    r.last = (b + 1 == active_bins());
                    expected_bins.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge aclk) begin
        stim_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.kind = ptah_pkg::kind_t'(s_kind);
                it.x = s_coord_x;
                it.y = s_coord_y;
                it.closes = s_closes_polygon;
                predict_histogram(it);
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= it.kind;
                    s_coord_x <= it.x;
                    s_coord_y <= it.y;
                    s_closes_polygon <= it.closes;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        bin_report_t r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    $error("unexpected result item: bin_index %0d", m_bin_index);
                    errors++;
                end else begin
                    r = expected_bins.pop_front();
                    if (m_bin_index !== r.bin) begin
                        $error("bin_index exp %0d got %0d", r.bin, m_bin_index);
                        errors++;
                    end
                    if (m_average_fraction !== r.share) begin
                        $error("average_fraction exp %0d got %0d", r.share,
                               m_average_fraction);
                        errors++;
                    end
                    if (m_polygons_seen !== r.total) begin
                        $error("polygons_seen exp %0d got %0d", r.total, m_polygons_seen);
                        errors++;
                    end
                    if (m_last_bin !== r.last) begin
                        $error("last_bin exp %0d got %0d", r.last, m_last_bin);
                        errors++;
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles with no item accepted on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [23:0] pick_coord(bit wide);
        if (wide) return 24'($urandom);
        return 24'($urandom_range(2000) - 1000);
    endfunction

    function automatic void push_item(ptah_pkg::kind_t k, int x, int y, bit closes);
        stim_item_t it;
        it.kind = k;
        it.x = 24'(x);
        it.y = 24'(y);
        it.closes = closes;
        pending_items.push_back(it);
    endfunction

    // one polygon of n vertices, optionally with repeated vertices
    function automatic void push_polygon(int n, bit wide, bit repeats);
        logic signed [23:0] x, y;
        for (int i = 0; i < n; i++) begin
            if (!(repeats && i > 0 && $urandom_range(2) == 0)) begin
                x = pick_coord(wide);
                y = pick_coord(wide);
            end
            push_item(ptah_pkg::KIND_VERTEX, int'(x), int'(y), i == n - 1);
        end
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_bins.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bins(int unsigned v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 7'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bin_setting = v;
    endtask

    initial begin
        int unsigned bin_plan [6];
        int          sel;
        reset_histogram();
        bin_plan = '{36, 0, 64, 127, 1, $urandom_range(2, 63)};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                sender_idle_pct = 50;
                receiver_idle_pct = 15;
            end else if (ph == 4) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            wait_idle();
            write_bins(bin_plan[ph]);

            if (ph == 0) begin
                // extreme corners, a square at full range
                push_item(ptah_pkg::KIND_VERTEX, -8388608, -8388608, 0);
                push_item(ptah_pkg::KIND_VERTEX, 8388607, -8388608, 0);
                push_item(ptah_pkg::KIND_VERTEX, 8388607, 8388607, 0);
                push_item(ptah_pkg::KIND_VERTEX, -8388608, 8388607, 1);
                // zero-length edge inside a triangle
                push_item(ptah_pkg::KIND_VERTEX, 5, 5, 0);
                push_item(ptah_pkg::KIND_VERTEX, 5, 5, 0);
                push_item(ptah_pkg::KIND_VERTEX, 10, 0, 1);
                // short polygons are dropped
                push_item(ptah_pkg::KIND_VERTEX, 100, -7, 1);
                push_item(ptah_pkg::KIND_VERTEX, 1, 2, 0);
                push_item(ptah_pkg::KIND_VERTEX, -3, 4, 1);
                // collinear polygon, then ignored kind and a read
                push_item(ptah_pkg::KIND_VERTEX, 0, 0, 0);
                push_item(ptah_pkg::KIND_VERTEX, 4, 0, 0);
                push_item(ptah_pkg::KIND_VERTEX, 8, 0, 1);
                push_item(ptah_pkg::KIND_NONE, -1, -1, 1);
                push_item(ptah_pkg::KIND_READ, 8388607, -8388608, 1);
                // clear with a polygon in progress, then read again
                push_item(ptah_pkg::KIND_VERTEX, -1, 0, 0);
                push_item(ptah_pkg::KIND_CLEAR, -8388608, 8388607, 1);
                push_item(ptah_pkg::KIND_VERTEX, 0, 0, 0);
                push_item(ptah_pkg::KIND_VERTEX, 0, 0, 0);
                push_item(ptah_pkg::KIND_VERTEX, 0, 0, 1);
                push_item(ptah_pkg::KIND_READ, 0, 0, 0);
            end

            // random part: mostly well-formed polygons
            while (pending_items.size() < 52) begin
                sel = $urandom_range(99);
                if (sel < 72)
                    push_polygon($urandom_range(3, 7), $urandom_range(1) == 1,
                                 $urandom_range(4) == 0);
                else if (sel < 80)
                    push_polygon($urandom_range(1, 2), $urandom_range(1) == 1, 1'b0);
                else if (sel < 86)
                    push_item(ptah_pkg::KIND_CLEAR, $urandom, $urandom,
                              $urandom_range(1) == 1);
                else if (sel < 94)
                    push_item(ptah_pkg::KIND_READ, $urandom, $urandom,
                              $urandom_range(1) == 1);
                else
                    push_item(ptah_pkg::KIND_NONE, $urandom, $urandom,
                              $urandom_range(1) == 1);
            end
            push_item(ptah_pkg::KIND_READ, $urandom, $urandom, $urandom_range(1) == 1);
        end

        wait_idle();
        repeat (500) @(posedge aclk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> polygon_turn_angle_histogram_core.f
rtl/core/ptah_pkg.sv
rtl/core/polygon_turn_angle_histogram_core.sv
dv/testbench.sv
